@@ rtl/gcwa_pkg.sv @@
`default_nettype none
package gcwa_pkg;

    localparam int DEF_MAX_RADIUS = 16;
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_PIXEL_BITS = 16;

    localparam int VALUE_W      = 16;
    localparam int RADIUS_W     = 5;
    localparam int FWIDTH_W     = 13;
    localparam int FHEIGHT_W    = 14;
    localparam int ROW_W        = 14;
    localparam int HEIGHT_LIMIT = 8192;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 14;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED       = 2'd3;

    localparam logic [RADIUS_W-1:0]  RESET_RADIUS       = 5'd2;
    localparam logic [FWIDTH_W-1:0]  RESET_FRAME_WIDTH  = 13'd4096;
    localparam logic [FHEIGHT_W-1:0] RESET_FRAME_HEIGHT = 14'd1080;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_HREAD,
        S_VREAD,
        S_WAIT,
        S_WRITE,
        S_DSTART,
        S_DIV,
        S_OUT
    } seq_state_t;

endpackage
`default_nettype wire

@@ rtl/gcwa_in_if.sv @@
`default_nettype none
interface gcwa_in_if;
    logic                        valid;
    logic                        ready;
    logic [gcwa_pkg::VALUE_W-1:0] pixel_value;
    logic                        is_pixel;
    logic                        frame_start;

    modport source (output valid, output pixel_value, output is_pixel, output frame_start,
                    input ready);
    modport sink (input valid, input pixel_value, input is_pixel, input frame_start,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/gcwa_out_if.sv @@
`default_nettype none
interface gcwa_out_if;
    logic                        valid;
    logic                        ready;
    logic [gcwa_pkg::VALUE_W-1:0] mask_value;
    logic                        frame_end;

    modport source (output valid, output mask_value, output frame_end, input ready);
    modport sink (input valid, input mask_value, input frame_end, output ready);
endinterface
`default_nettype wire

@@ rtl/gated_cross_window_average.sv @@
// channel   | dir | beat fields
// pixel_in  | in  | pixel_value[15:0], is_pixel, frame_start
// mask_out  | out | mask_value[15:0], frame_end
// config    | in  | write_enable, write_index[1:0], write_data[13:0]
//
// One item at a time. An item with a result reads its clipped cross window
// through the single read port of the row store and then waits on the
// bit-serial divider (SUM_W = PIXEL_BITS + clog2(4*MAX_RADIUS)). A pixel that
// yields no result is only written to the row store, and a flush with nothing
// to drain is dropped. Reset clears control only; the row store is not cleared.
// A finished beat waits in the output register while the next item is taken.
`default_nettype none
module gated_cross_window_average #(
    parameter int MAX_RADIUS = gcwa_pkg::DEF_MAX_RADIUS,
    parameter int MAX_WIDTH  = gcwa_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = gcwa_pkg::DEF_PIXEL_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    gcwa_in_if.sink                              pixel_in,
    gcwa_out_if.source                           mask_out,
    input  wire logic                            write_enable,
    input  wire logic [gcwa_pkg::CFG_IDX_W-1:0]  write_index,
    input  wire logic [gcwa_pkg::CFG_DATA_W-1:0] write_data
);

    localparam int ROW_W      = gcwa_pkg::ROW_W;
    localparam int CW         = ROW_W + 1;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = $clog2(MAX_WIDTH + 1);
    localparam int ARM_W      = $clog2(MAX_RADIUS);
    localparam int STORE_ROWS = 2 * (MAX_RADIUS - 1);
    localparam int SLOT_W     = $clog2(STORE_ROWS);
    localparam int SW         = SLOT_W + 1;
    localparam int DEPTH      = STORE_ROWS * MAX_WIDTH;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int N_W        = $clog2(4 * MAX_RADIUS);
    localparam int SUM_W      = PIXEL_BITS + N_W;

    gcwa_pkg::seq_state_t state_reg, state_next;

    logic [gcwa_pkg::RADIUS_W-1:0]  radius_reg;
    logic [gcwa_pkg::FWIDTH_W-1:0]  fwidth_reg;
    logic [gcwa_pkg::FHEIGHT_W-1:0] fheight_reg;

    logic                  running_reg;
    logic [ARM_W-1:0]      arm_reg;
    logic [WID_W-1:0]      eff_w_reg;
    logic [ROW_W-1:0]      eff_h_reg;
    logic [COL_W-1:0]      in_col_reg, out_col_reg;
    logic [ROW_W-1:0]      in_row_reg, out_row_reg;
    logic [SLOT_W-1:0]     in_slot_reg, out_slot_reg;

    logic [PIXEL_BITS-1:0] pix_reg;
    logic                  is_pix_reg;
    logic                  has_out_reg;
    logic [COL_W-1:0]      hcol_reg, hh_reg;
    logic [SLOT_W-1:0]     vslot_reg;
    logic [N_W-1:0]        vleft_reg;
    logic [N_W-1:0]        n_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic                  rd_pend_reg, rd_centre_reg;
    logic                  centre_zero_reg;

    logic                        out_valid_reg;
    logic [gcwa_pkg::VALUE_W-1:0] res_value_reg;
    logic                        res_end_reg;

    logic                  in_beat;
    logic                  frame_go;
    logic                  go;
    logic                  out_free;
    logic [SW-1:0]         rows2;
    logic [CW-1:0]         x_w, y_w, a_w, ew, eh;
    logic [CW-1:0]         hl, hh, vd, vh, vcnt, ntot;
    logic [SW-1:0]         vstart;

    logic                  mem_we, mem_re;
    logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
    logic [PIXEL_BITS-1:0] mem_rdata;

    logic                  div_start, div_done;
    logic [SUM_W-1:0]      div_q;

    function automatic logic [ADDR_W-1:0] slot_addr(logic [SLOT_W-1:0] s, logic [COL_W-1:0] c);
        slot_addr = ADDR_W'(s) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
    endfunction

    assign in_beat  = pixel_in.valid && pixel_in.ready;
    assign out_free = !out_valid_reg || mask_out.ready;
    assign rows2    = {arm_reg, 1'b0} > SW'(0) ? SW'({arm_reg, 1'b0}) : SW'(2);

    always_comb
    begin
        frame_go = pixel_in.frame_start || !running_reg || (in_row_reg >= eff_h_reg);
        x_w  = CW'(out_col_reg);
        y_w  = CW'(out_row_reg);
        a_w  = CW'(arm_reg);
        ew   = CW'(eff_w_reg);
        eh   = CW'(eff_h_reg);
        hl   = (x_w > a_w) ? x_w - a_w : '0;
        hh   = (x_w + a_w < ew) ? x_w + a_w : ew - CW'(1);
        vd   = (y_w > a_w) ? a_w : y_w;
        vh   = (y_w + a_w < eh) ? y_w + a_w : eh - CW'(1);
        vcnt = vh - (y_w - vd) + CW'(1);
        ntot = hh - hl + CW'(1) + vcnt;
        if (SW'(out_slot_reg) >= SW'(vd))
        begin
            vstart = SW'(out_slot_reg) - SW'(vd);
        end
        else
        begin
            vstart = SW'(out_slot_reg) + rows2 - SW'(vd);
        end
        if (is_pix_reg)
        begin
            go = in_row_reg >= ROW_W'(arm_reg);
        end
        else
        begin
            go = running_reg && (in_row_reg >= eff_h_reg) && (out_row_reg < eff_h_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gcwa_pkg::S_IDLE:   if (in_beat) state_next = gcwa_pkg::S_SETUP;
            gcwa_pkg::S_SETUP:
            begin
                priority if (go)        state_next = gcwa_pkg::S_HREAD;
                else if (is_pix_reg)    state_next = gcwa_pkg::S_WRITE;
                else                    state_next = gcwa_pkg::S_IDLE;
            end
            gcwa_pkg::S_HREAD:  if (hcol_reg == hh_reg) state_next = gcwa_pkg::S_VREAD;
            gcwa_pkg::S_VREAD:  if (vleft_reg == N_W'(1)) state_next = gcwa_pkg::S_WAIT;
            gcwa_pkg::S_WAIT:
                state_next = is_pix_reg ? gcwa_pkg::S_WRITE : gcwa_pkg::S_DSTART;
            gcwa_pkg::S_WRITE:
                state_next = has_out_reg ? gcwa_pkg::S_DSTART : gcwa_pkg::S_IDLE;
            gcwa_pkg::S_DSTART: state_next = gcwa_pkg::S_DIV;
            gcwa_pkg::S_DIV:    if (div_done) state_next = gcwa_pkg::S_OUT;
            gcwa_pkg::S_OUT:    if (out_free) state_next = gcwa_pkg::S_IDLE;
            default:            state_next = gcwa_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        pixel_in.ready = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = slot_addr(out_slot_reg, hcol_reg);
        mem_waddr      = slot_addr(in_slot_reg, in_col_reg);
        div_start      = 1'b0;
        unique case (state_reg)
            gcwa_pkg::S_IDLE:   pixel_in.ready = 1'b1;
            gcwa_pkg::S_HREAD:  mem_re = 1'b1;
            gcwa_pkg::S_VREAD:
            begin
                mem_re    = 1'b1;
                mem_raddr = slot_addr(vslot_reg, out_col_reg);
            end
            gcwa_pkg::S_WRITE:  mem_we = 1'b1;
            gcwa_pkg::S_DSTART: div_start = 1'b1;
            default:            ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gcwa_pkg::S_IDLE;
            radius_reg    <= gcwa_pkg::RESET_RADIUS;
            fwidth_reg    <= gcwa_pkg::RESET_FRAME_WIDTH;
            fheight_reg   <= gcwa_pkg::RESET_FRAME_HEIGHT;
            running_reg   <= 1'b0;
            arm_reg       <= ARM_W'(1);
            eff_w_reg     <= WID_W'(MAX_WIDTH);
            eff_h_reg     <= ROW_W'(1080);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_slot_reg   <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_slot_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= mem_re;
            if (write_enable)
            begin
                unique case (write_index)
                    gcwa_pkg::REG_RADIUS:
                        radius_reg <= write_data[gcwa_pkg::RADIUS_W-1:0];
                    gcwa_pkg::REG_FRAME_WIDTH:
                        fwidth_reg <= write_data[gcwa_pkg::FWIDTH_W-1:0];
                    gcwa_pkg::REG_FRAME_HEIGHT:
                        fheight_reg <= write_data[gcwa_pkg::FHEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == gcwa_pkg::S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (mask_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == gcwa_pkg::S_IDLE && in_beat && pixel_in.is_pixel && frame_go)
            begin
                running_reg <= 1'b1;
                priority if (radius_reg < gcwa_pkg::RADIUS_W'(2))
                    arm_reg <= ARM_W'(1);
                else if (32'(radius_reg) > MAX_RADIUS)
                    arm_reg <= ARM_W'(MAX_RADIUS - 1);
                else
                    arm_reg <= ARM_W'(radius_reg - gcwa_pkg::RADIUS_W'(1));
                priority if (fwidth_reg == '0)
                    eff_w_reg <= WID_W'(1);
                else if (32'(fwidth_reg) > MAX_WIDTH)
                    eff_w_reg <= WID_W'(MAX_WIDTH);
                else
                    eff_w_reg <= WID_W'(fwidth_reg);
                priority if (fheight_reg == '0)
                    eff_h_reg <= ROW_W'(1);
                else if (32'(fheight_reg) > gcwa_pkg::HEIGHT_LIMIT)
                    eff_h_reg <= ROW_W'(gcwa_pkg::HEIGHT_LIMIT);
                else
                    eff_h_reg <= ROW_W'(fheight_reg);
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                in_slot_reg  <= '0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                out_slot_reg <= '0;
            end
            if (state_reg == gcwa_pkg::S_WRITE)
            begin
                if (WID_W'(in_col_reg) == eff_w_reg - WID_W'(1))
                begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_reg + ROW_W'(1);
                    in_slot_reg <= (SW'(in_slot_reg) == rows2 - SW'(1)) ? '0
                                   : in_slot_reg + SLOT_W'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + COL_W'(1);
                end
            end
            if (state_reg == gcwa_pkg::S_OUT && out_free)
            begin
                if (WID_W'(out_col_reg) == eff_w_reg - WID_W'(1))
                begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + ROW_W'(1);
                    out_slot_reg <= (SW'(out_slot_reg) == rows2 - SW'(1)) ? '0
                                    : out_slot_reg + SLOT_W'(1);
                end
                else
                begin
                    out_col_reg <= out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == gcwa_pkg::S_IDLE && in_beat)
        begin
            pix_reg    <= pixel_in.pixel_value[PIXEL_BITS-1:0];
            is_pix_reg <= pixel_in.is_pixel;
        end
        if (state_reg == gcwa_pkg::S_SETUP)
        begin
            has_out_reg <= go;
            hcol_reg    <= COL_W'(hl);
            hh_reg      <= COL_W'(hh);
            vslot_reg   <= SLOT_W'(vstart);
            vleft_reg   <= N_W'(vcnt) - N_W'(is_pix_reg);
            n_reg       <= N_W'(ntot);
            sum_reg     <= is_pix_reg ? SUM_W'(pix_reg) : '0;
        end
        if (state_reg == gcwa_pkg::S_HREAD)
        begin
            hcol_reg <= hcol_reg + COL_W'(1);
        end
        if (state_reg == gcwa_pkg::S_VREAD)
        begin
            vleft_reg <= vleft_reg - N_W'(1);
            vslot_reg <= (SW'(vslot_reg) == rows2 - SW'(1)) ? '0 : vslot_reg + SLOT_W'(1);
        end
        rd_centre_reg <= (state_reg == gcwa_pkg::S_HREAD) && (hcol_reg == out_col_reg);
        if (rd_pend_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(mem_rdata);
            if (rd_centre_reg)
            begin
                centre_zero_reg <= mem_rdata == '0;
            end
        end
        if (state_reg == gcwa_pkg::S_OUT && out_free)
        begin
            res_value_reg <= centre_zero_reg ? '0
                             : gcwa_pkg::VALUE_W'(div_q[PIXEL_BITS-1:0]);
            res_end_reg   <= (WID_W'(out_col_reg) == eff_w_reg - WID_W'(1))
                             && (out_row_reg == eff_h_reg - ROW_W'(1));
        end
    end

    gcwa_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (PIXEL_BITS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (pix_reg),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    gcwa_div #(
        .SUM_W (SUM_W),
        .N_W   (N_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign mask_out.valid      = out_valid_reg;
    assign mask_out.mask_value = res_value_reg;
    assign mask_out.frame_end  = res_end_reg;

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("row store read and write in one cycle");

    a_read_origin: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> ($past(state_reg) == gcwa_pkg::S_HREAD
                         || $past(state_reg) == gcwa_pkg::S_VREAD))
        else $error("read data without a read");

    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == gcwa_pkg::S_DIV)
        else $error("quotient outside divide wait");

endmodule
`default_nettype wire

@@ rtl/gcwa_store.sv @@
`default_nettype none
module gcwa_store #(
    parameter int DEPTH  = 2,
    parameter int ADDR_W = 1,
    parameter int DATA_W = 16
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/gcwa_div.sv @@
`default_nettype none
module gcwa_div #(
    parameter int SUM_W = 22,
    parameter int N_W   = 6
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] dividend,
    input  wire logic [N_W-1:0]   divisor,
    output logic                  done,
    output logic      [SUM_W-1:0] quotient
);

    localparam int CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    logic [N_W-1:0]     rem_reg, rem_next;
    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic               run_reg;
    logic               done_reg;
    logic [N_W:0]       trial;
    logic               fits;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[SUM_W-1]};
        fits     = trial >= {1'b0, divisor};
        rem_next = fits ? N_W'(trial - {1'b0, divisor}) : N_W'(trial);
        quo_next = {quo_reg[SUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(SUM_W - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

@@ tb/gcwa_scoreboard.sv @@
class mask_scoreboard;

    typedef struct {
        bit [15:0] mask_value;
        bit        frame_end;
    } mask_beat_t;

    localparam int STORE_ROWS = 2 * (gcwa_pkg::DEF_MAX_RADIUS - 1);
    localparam int MAXW       = gcwa_pkg::DEF_MAX_WIDTH;

    bit [15:0]   row_pixels [STORE_ROWS*MAXW];
    mask_beat_t  mask_queue [$];
    int unsigned radius_reg, width_reg, height_reg;
    int unsigned arm, eff_w, eff_h;
    int unsigned in_col, in_row, out_col, out_row;
    bit          running;
    int          mismatches;
    int          unexpected;

    function new();
        radius_reg = gcwa_pkg::RESET_RADIUS;
        width_reg  = gcwa_pkg::RESET_FRAME_WIDTH;
        height_reg = gcwa_pkg::RESET_FRAME_HEIGHT;
        arm        = 1;
        eff_w      = MAXW;
        eff_h      = 1080;
        running    = 0;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        mismatches = 0;
        unexpected = 0;
    endfunction

    function void write_reg(bit [1:0] idx, bit [13:0] data);
        if (idx == gcwa_pkg::REG_RADIUS)
            radius_reg = data[4:0];
        else if (idx == gcwa_pkg::REG_FRAME_WIDTH)
            width_reg = data[12:0];
        else if (idx == gcwa_pkg::REG_FRAME_HEIGHT)
            height_reg = data;
    endfunction

    function int unsigned slot(int unsigned row, int unsigned col);
        return (row % (2 * arm)) * MAXW + col;
    endfunction

    function bit [15:0] window_mean(int unsigned x, int unsigned y, bit live,
                                    int unsigned live_row, bit [15:0] live_val);
        int unsigned sum, n, lo, hi;
        sum = 0;
        n = 0;
        if (row_pixels[slot(y, x)] == 0)
            return 0;
        lo = (x > arm) ? x - arm : 0;
        hi = (x + arm < eff_w) ? x + arm : eff_w - 1;
        for (int unsigned i = lo; i <= hi; i++)
        begin
            sum += row_pixels[slot(y, i)];
            n++;
        end
        lo = (y > arm) ? y - arm : 0;
        hi = (y + arm < eff_h) ? y + arm : eff_h - 1;
        for (int unsigned i = lo; i <= hi; i++)
        begin
            sum += (live && i == live_row) ? live_val : row_pixels[slot(i, x)];
            n++;
        end
        return 16'(sum / n);
    endfunction

    function void push_mask(bit [15:0] value);
        mask_beat_t b;
        b.mask_value = value;
        b.frame_end  = (out_col == eff_w - 1 && out_row == eff_h - 1);
        mask_queue.push_back(b);
        out_col++;
        if (out_col >= eff_w)
        begin
            out_col = 0;
            out_row++;
        end
    endfunction

    function void note_pixel(bit [15:0] v, bit is_pixel, bit frame_start);
        if (!is_pixel)
        begin
            if (running && in_row >= eff_h && out_row < eff_h)
                push_mask(window_mean(out_col, out_row, 0, 0, 0));
            return;
        end
        if (frame_start || !running || in_row >= eff_h)
        begin
            arm   = radius_reg < 2 ? 1 : (radius_reg > 16 ? 15 : radius_reg - 1);
            eff_w = width_reg < 1 ? 1 : (width_reg > MAXW ? MAXW : width_reg);
            eff_h = height_reg < 1 ? 1 : (height_reg > 8192 ? 8192 : height_reg);
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            running = 1;
        end
        if (in_row >= arm)
            push_mask(window_mean(in_col, in_row - arm, 1, in_row, v));
        row_pixels[slot(in_row, in_col)] = v;
        in_col++;
        if (in_col >= eff_w)
        begin
            in_col = 0;
            in_row++;
        end
    endfunction

    function void check_mask(bit [15:0] mask_value, bit frame_end);
        mask_beat_t b;
        if (mask_queue.size() == 0)
        begin
            unexpected++;
            if (mismatches + unexpected <= 10)
                $display("unexpected beat: mask_value=%0d frame_end=%0b", mask_value, frame_end);
            return;
        end
        b = mask_queue.pop_front();
        if (b.mask_value !== mask_value || b.frame_end !== frame_end)
        begin
            mismatches++;
            if (mismatches + unexpected <= 10)
                $display("mismatch: mask_value exp %0d got %0d, frame_end exp %0b got %0b",
                         b.mask_value, mask_value, b.frame_end, frame_end);
        end
    endfunction

    function int pending();
        return mask_queue.size();
    endfunction

endclass

@@ tb/tb_gated_cross_window_average.sv @@
module tb_gated_cross_window_average;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 200;

    logic                            clk;
    logic                            rst_n;
    logic                            write_enable;
    logic [gcwa_pkg::CFG_IDX_W-1:0]  write_index;
    logic [gcwa_pkg::CFG_DATA_W-1:0] write_data;

    gcwa_in_if  pin();
    gcwa_out_if mout();

    gated_cross_window_average uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_in     (pin),
        .mask_out     (mout),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data)
    );

    mask_scoreboard sb = new();

    int  items_sent;
    int  idle_cycles;
    int  out_stall;
    bit  no_idle;
    int  cur_arm, cur_w;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (mout.valid && mout.ready)
                sb.check_mask(mout.mask_value, mout.frame_end);
            if ((pin.valid && pin.ready) || (mout.valid && mout.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
            if (out_stall > 0)
            begin
                mout.ready <= 1'b0;
                out_stall <= out_stall - 1;
            end
            else
            begin
                mout.ready <= 1'b1;
                out_stall <= pick_gap();
            end
        end
    end

    task automatic send_item(bit [15:0] v, bit is_pixel, bit frame_start);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            pin.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pin.valid       <= 1'b1;
        pin.pixel_value <= v;
        pin.is_pixel    <= is_pixel;
        pin.frame_start <= frame_start;
        do
            @(posedge clk);
        while (!pin.ready);
        sb.note_pixel(v, is_pixel, frame_start);
        items_sent++;
    endtask

    task automatic hold_until_drained();
        pin.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(bit [1:0] idx, bit [13:0] data);
        write_enable <= 1'b1;
        write_index  <= idx;
        write_data   <= data;
        sb.write_reg(idx, data);
        @(posedge clk);
        write_enable <= 1'b0;
    endtask

    task automatic configure(int radius, int width, int height);
        hold_until_drained();
        write_reg(gcwa_pkg::REG_RADIUS, 14'(radius));
        write_reg(gcwa_pkg::REG_FRAME_WIDTH, 14'(width));
        write_reg(gcwa_pkg::REG_FRAME_HEIGHT, 14'(height));
        cur_arm = (radius % 32) < 2 ? 1 : ((radius % 32) > 16 ? 15 : (radius % 32) - 1);
        cur_w   = (width % 8192) < 1 ? 1 : ((width % 8192) > 4096 ? 4096 : width % 8192);
    endtask

    function bit [15:0] pick_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return 16'd0;
        if (r < 32)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    task automatic run_frame(int npix, int nflush, bit mark_start);
        for (int i = 0; i < npix; i++)
        begin
            if ($urandom_range(0, 99) < 3)
                send_item(16'($urandom), 1'b0, 1'($urandom));
            send_item(pick_pixel(), 1'b1, (i == 0) && mark_start);
        end
        for (int i = 0; i < nflush; i++)
            send_item(16'($urandom), 1'b0, 1'($urandom));
    endtask

    initial
    begin
        int w, h, r, frames;
        bit [15:0] directed [9];
        rst_n           = 1'b0;
        pin.valid       = 1'b0;
        pin.pixel_value = '0;
        pin.is_pixel    = 1'b0;
        pin.frame_start = 1'b0;
        mout.ready      = 1'b0;
        write_enable    = 1'b0;
        write_index     = '0;
        write_data      = '0;
        items_sent      = 0;
        idle_cycles     = 0;
        out_stall       = 0;
        no_idle         = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{16'hFFFF, 16'd0, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd2, 16'd0,
                     16'hFFFF};
        configure(2, 3, 3);
        write_reg(gcwa_pkg::REG_UNUSED, 14'h3FFF);
        send_item(16'd5, 1'b0, 1'b1);
        for (int i = 0; i < 9; i++)
        begin
            send_item(directed[i], 1'b1, i == 0);
            if (i == 4)
                send_item(16'd0, 1'b0, 1'b0);
        end
        for (int i = 0; i < 4; i++)
            send_item(16'hFFFF, 1'b0, 1'b0);
        configure(0, 0, 0);
        send_item(16'd7, 1'b1, 1'b0);
        send_item(16'd0, 1'b1, 1'b0);
        send_item(16'd0, 1'b0, 1'b0);
        configure(31, 2, 16383);
        run_frame(40, 0, 1);
        configure(16, 8191, 2);
        run_frame(20, 0, 1);
        configure(16, 4096, 8192);
        run_frame(6, 0, 1);

        while (items_sent < 1050)
        begin
            r = $urandom_range(2, 16);
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 12);
            if ($urandom_range(0, 9) == 0)
                w = 1;
            configure(r, w, h);
            no_idle = ($urandom_range(0, 4) == 0);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames && items_sent < 1050; f++)
            begin
                if ($urandom_range(0, 9) == 0)
                    run_frame($urandom_range(1, w * h), 0, 1);
                else
                    run_frame(w * h, cur_w * cur_arm + $urandom_range(0, 2),
                              $urandom_range(0, 4) != 0);
                if ($urandom_range(0, 19) == 0)
                    hold_until_drained();
            end
        end

        pin.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ gated_cross_window_average.f @@
rtl/gcwa_pkg.sv
rtl/gcwa_in_if.sv
rtl/gcwa_out_if.sv
rtl/gcwa_store.sv
rtl/gcwa_div.sv
rtl/gated_cross_window_average.sv
tb/gcwa_scoreboard.sv
tb/tb_gated_cross_window_average.sv
